// File: design/lsar_pkg.sv
// Shared types, constants and lookup tables for the lidar sector avoidance reflex unit.
package lsar_pkg;

	localparam int INDEX_BITS_DEF = 11;
	localparam int IDX_W = 12;
	localparam int RANGE_W = 16;
	localparam int CNT_W = 5;
	localparam int NUM_SLOTS = 7;
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic [2:0] REG_WALL_THRESHOLD = 3'd0;
	localparam logic [2:0] REG_NEAR_CONTACT = 3'd1;
	localparam logic [2:0] REG_CRASH_REAR_LEFT = 3'd2;
	localparam logic [2:0] REG_CRASH_REAR = 3'd3;
	localparam logic [2:0] REG_CRASH_RIGHT = 3'd4;
	localparam logic [2:0] REG_CRASH_FRONT = 3'd5;

	localparam logic [RANGE_W-1:0] WALL_THRESHOLD_RST = 16'd550;
	localparam logic [RANGE_W-1:0] NEAR_CONTACT_RST = 16'd250;
	localparam logic [RANGE_W-1:0] CRASH_REAR_LEFT_RST = 16'd250;
	localparam logic [RANGE_W-1:0] CRASH_REAR_RST = 16'd300;
	localparam logic [RANGE_W-1:0] CRASH_RIGHT_RST = 16'd240;
	localparam logic [RANGE_W-1:0] CRASH_FRONT_RST = 16'd190;

	localparam logic [IDX_W-1:0] LEFT_A_HI = 12'd46;
	localparam logic [IDX_W-1:0] LEFT_B_LO = 12'd1825;
	localparam logic [IDX_W-1:0] LEFT_B_HI = 12'd1976;
	localparam logic [IDX_W-1:0] FRONT_LO = 12'd1139;
	localparam logic [IDX_W-1:0] FRONT_HI = 12'd1599;
	localparam logic [IDX_W-1:0] RIGHT_LO = 12'd824;
	localparam logic [IDX_W-1:0] RIGHT_HI = 12'd876;
	localparam logic [IDX_W-1:0] PROBE_RIGHT = 12'd820;
	localparam logic [IDX_W-1:0] PROBE_LEFT = 12'd1890;
	localparam logic [IDX_W-1:0] BAND_RL_A_LO = 12'd1;
	localparam logic [IDX_W-1:0] BAND_RL_A_HI = 12'd47;
	localparam logic [IDX_W-1:0] BAND_REAR_HI = 12'd582;
	localparam logic [IDX_W-1:0] BAND_RIGHT_HI = 12'd912;
	localparam logic [IDX_W-1:0] BAND_FRONT_HI = 12'd1802;
	localparam logic [IDX_W-1:0] BAND_RL_B_HI = 12'd1999;
	localparam logic [IDX_W-1:0] QUAD_RL_HI = 12'd300;
	localparam logic [IDX_W-1:0] QUAD_RR_HI = 12'd820;
	localparam logic [IDX_W-1:0] QUAD_FR_HI = 12'd1361;
	localparam logic [IDX_W-1:0] QUAD_FL_HI = 12'd1890;

	localparam logic [2:0] SLOT_CASE15 = 3'd6;
	localparam logic [2:0] SLOT_NONE = 3'd7;
	localparam logic [CNT_W-1:0] RETRY_A_LIMIT = 5'd7;
	localparam logic [CNT_W-1:0] RETRY_B_LIMIT = 5'd15;
	localparam logic [CNT_W-1:0] C15_FWD_LIMIT = 5'd4;
	localparam logic [CNT_W-1:0] C15_BACK_LIMIT = 5'd8;
	localparam logic [CNT_W-1:0] C15_TURN_LIMIT = 5'd20;

	localparam logic signed [7:0] CMD_C15_FWD = 8'sd10;
	localparam logic signed [7:0] CMD_C15_BACK = -8'sd10;
	localparam logic signed [7:0] CMD_C15_TURN = -8'sd50;
	localparam logic signed [7:0] CMD_NEAR_LIN = 8'sd30;
	localparam logic signed [7:0] CMD_NEAR_RIGHT_ANG = 8'sd100;
	localparam logic signed [7:0] CMD_NEAR_LEFT_ANG = -8'sd100;

	typedef struct packed {
		logic [RANGE_W-1:0] wall_threshold_mm;
		logic [RANGE_W-1:0] near_contact_mm;
		logic [RANGE_W-1:0] crash_rear_left_mm;
		logic [RANGE_W-1:0] crash_rear_mm;
		logic [RANGE_W-1:0] crash_right_mm;
		logic [RANGE_W-1:0] crash_front_mm;
	} cfg_t;

	typedef struct packed {
		logic [2:0] wall;
		logic [3:0] quad;
		logic [1:0] near;
	} flags_t;

	typedef struct packed {
		logic signed [7:0] linear_cmd;
		logic signed [7:0] angular_cmd;
		logic crash_mode;
		logic [3:0] quadrant_code;
		logic unrecoverable;
		logic last_result;
	} result_t;

	typedef struct packed {
		logic signed [7:0] lin;
		logic signed [7:0] ang;
	} cmd_t;

	typedef struct packed {
		logic signed [7:0] lin_a;
		logic signed [7:0] ang_a;
		logic signed [7:0] lin_b;
		logic signed [7:0] ang_b;
		logic [2:0] slot;
	} crash_entry_t;

	function automatic crash_entry_t crash_entry(input logic [3:0] q);
		crash_entry_t e;
		unique case (q)
			4'd0: e = '{8'sd0, 8'sd0, 8'sd0, 8'sd0, SLOT_NONE};
			4'd1: e = '{8'sd50, -8'sd50, 8'sd0, 8'sd0, SLOT_NONE};
			4'd2: e = '{8'sd50, 8'sd50, 8'sd0, 8'sd0, SLOT_NONE};
			4'd3: e = '{8'sd100, 8'sd0, 8'sd0, 8'sd0, SLOT_NONE};
			4'd4: e = '{-8'sd50, -8'sd50, 8'sd0, 8'sd0, SLOT_NONE};
			4'd5: e = '{8'sd10, 8'sd50, -8'sd10, -8'sd50, 3'd0};
			4'd6: e = '{8'sd50, 8'sd50, 8'sd0, 8'sd0, SLOT_NONE};
			4'd7: e = '{8'sd10, 8'sd50, -8'sd10, -8'sd50, 3'd1};
			4'd8: e = '{-8'sd50, 8'sd50, 8'sd0, 8'sd0, SLOT_NONE};
			4'd9: e = '{8'sd50, -8'sd50, 8'sd0, 8'sd0, SLOT_NONE};
			4'd10: e = '{8'sd10, -8'sd50, -8'sd10, 8'sd50, 3'd2};
			4'd11: e = '{8'sd10, -8'sd50, -8'sd10, 8'sd50, 3'd3};
			4'd12: e = '{-8'sd50, 8'sd0, 8'sd0, 8'sd0, SLOT_NONE};
			4'd13: e = '{-8'sd10, 8'sd50, 8'sd10, -8'sd50, 3'd4};
			4'd14: e = '{-8'sd10, -8'sd50, 8'sd10, 8'sd50, 3'd5};
			default: e = '{8'sd0, 8'sd0, 8'sd0, 8'sd0, SLOT_CASE15};
		endcase
		return e;
	endfunction

	function automatic cmd_t wall_cmd(input logic [2:0] w);
		cmd_t c;
		unique case (w)
			3'd0: c = '{8'sd50, -8'sd77};
			3'd1: c = '{8'sd50, -8'sd65};
			3'd2: c = '{8'sd0, 8'sd50};
			3'd3: c = '{8'sd0, 8'sd50};
			3'd4: c = '{8'sd50, 8'sd0};
			3'd5: c = '{8'sd50, 8'sd0};
			3'd6: c = '{8'sd0, 8'sd50};
			default: c = '{8'sd0, 8'sd50};
		endcase
		return c;
	endfunction

endpackage

// File: design/lsar_scan.sv
// Per-sample sector classification and the scan flag registers.
module lsar_scan #(
	parameter int INDEX_BITS = lsar_pkg::INDEX_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               fire,
	input  logic [INDEX_BITS-1:0]              sample_index,
	input  logic [lsar_pkg::RANGE_W-1:0]       range_mm,
	input  logic                               last_sample,
	input  lsar_pkg::cfg_t                     cfg,
	output lsar_pkg::flags_t                   flags
);

	localparam int IdxW = lsar_pkg::IDX_W;

	lsar_pkg::flags_t flags_q;
	logic [IdxW-1:0] idx;
	logic [lsar_pkg::RANGE_W-1:0] crash_th;
	logic in_band;
	logic crash;

	always_comb begin
		idx = IdxW'(sample_index);
		flags = flags_q;

		if (range_mm < cfg.wall_threshold_mm) begin
			if (idx <= lsar_pkg::LEFT_A_HI ||
					(idx >= lsar_pkg::LEFT_B_LO && idx <= lsar_pkg::LEFT_B_HI)) begin
				flags.wall[0] = 1'b1;
			end
			if (idx >= lsar_pkg::FRONT_LO && idx <= lsar_pkg::FRONT_HI) begin
				flags.wall[1] = 1'b1;
			end
			if (idx >= lsar_pkg::RIGHT_LO && idx <= lsar_pkg::RIGHT_HI) begin
				flags.wall[2] = 1'b1;
			end
		end
		if (range_mm < cfg.near_contact_mm) begin
			if (idx == lsar_pkg::PROBE_RIGHT) flags.near[0] = 1'b1;
			if (idx == lsar_pkg::PROBE_LEFT) flags.near[1] = 1'b1;
		end

		in_band = 1'b1;
		priority if (idx >= lsar_pkg::BAND_RL_A_LO && idx <= lsar_pkg::BAND_RL_A_HI) begin
			crash_th = cfg.crash_rear_left_mm;
		end else if (idx > lsar_pkg::BAND_RL_A_HI && idx <= lsar_pkg::BAND_REAR_HI) begin
			crash_th = cfg.crash_rear_mm;
		end else if (idx > lsar_pkg::BAND_REAR_HI && idx <= lsar_pkg::BAND_RIGHT_HI) begin
			crash_th = cfg.crash_right_mm;
		end else if (idx > lsar_pkg::BAND_RIGHT_HI && idx <= lsar_pkg::BAND_FRONT_HI) begin
			crash_th = cfg.crash_front_mm;
		end else if (idx > lsar_pkg::BAND_FRONT_HI && idx <= lsar_pkg::BAND_RL_B_HI) begin
			crash_th = cfg.crash_rear_left_mm;
		end else begin
			crash_th = '0;
			in_band = 1'b0;
		end
		crash = in_band && (range_mm < crash_th);

		if (crash) begin
			if (idx <= lsar_pkg::QUAD_RL_HI || idx >= lsar_pkg::QUAD_FL_HI) flags.quad[0] = 1'b1;
			if (idx >= lsar_pkg::QUAD_RL_HI && idx <= lsar_pkg::QUAD_RR_HI) flags.quad[1] = 1'b1;
			if (idx >= lsar_pkg::QUAD_RR_HI && idx <= lsar_pkg::QUAD_FR_HI) flags.quad[2] = 1'b1;
			if (idx >= lsar_pkg::QUAD_FR_HI && idx <= lsar_pkg::QUAD_FL_HI) flags.quad[3] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (fire) begin
			flags_q <= last_sample ? '0 : flags;
		end
	end

endmodule

// File: design/lsar_decide.sv
// End-of-scan command decision with the crash recovery retry counters.
module lsar_decide (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire_last,
	input  lsar_pkg::flags_t   flags,
	output lsar_pkg::result_t  res0,
	output lsar_pkg::result_t  res1,
	output logic               crash_scan
);

	localparam int CntW = lsar_pkg::CNT_W;

	logic [CntW-1:0] cnt_q [lsar_pkg::NUM_SLOTS];
	lsar_pkg::crash_entry_t e;
	lsar_pkg::cmd_t wc;
	logic [CntW-1:0] cur_cnt;
	logic [CntW-1:0] cnt_next;
	logic cnt_we;
	logic signed [7:0] lin;
	logic signed [7:0] ang;
	logic unrec;

	always_comb begin
		e = lsar_pkg::crash_entry(flags.quad);
		wc = lsar_pkg::wall_cmd(flags.wall);
		crash_scan = (flags.quad != 4'd0);
		cur_cnt = '0;
		for (int i = 0; i < lsar_pkg::NUM_SLOTS; i++) begin
			if (e.slot == 3'(i)) cur_cnt = cnt_q[i];
		end
		cnt_next = cur_cnt + CntW'(1);
		cnt_we = 1'b0;
		lin = 8'sd0;
		ang = 8'sd0;
		unrec = 1'b0;

		if (crash_scan) begin
			if (e.slot == lsar_pkg::SLOT_NONE) begin
				lin = e.lin_a;
				ang = e.ang_a;
			end else if (e.slot == lsar_pkg::SLOT_CASE15) begin
				cnt_we = 1'b1;
				priority if (cur_cnt < lsar_pkg::C15_FWD_LIMIT) begin
					lin = lsar_pkg::CMD_C15_FWD;
				end else if (cur_cnt < lsar_pkg::C15_BACK_LIMIT) begin
					lin = lsar_pkg::CMD_C15_BACK;
				end else if (cur_cnt < lsar_pkg::C15_TURN_LIMIT) begin
					ang = lsar_pkg::CMD_C15_TURN;
				end else begin
					cnt_next = '0;
					unrec = 1'b1;
				end
			end else begin
				cnt_we = 1'b1;
				priority if (cur_cnt < lsar_pkg::RETRY_A_LIMIT) begin
					lin = e.lin_a;
					ang = e.ang_a;
				end else if (cur_cnt < lsar_pkg::RETRY_B_LIMIT) begin
					lin = e.lin_b;
					ang = e.ang_b;
				end else begin
					cnt_next = '0;
					unrec = 1'b1;
				end
			end
		end else begin
			lin = wc.lin;
			ang = wc.ang;
			if (flags.near[0]) begin
				lin = lsar_pkg::CMD_NEAR_LIN;
				ang = lsar_pkg::CMD_NEAR_RIGHT_ANG;
			end
			if (flags.near[1]) begin
				lin = lsar_pkg::CMD_NEAR_LIN;
				ang = lsar_pkg::CMD_NEAR_LEFT_ANG;
			end
		end

		res0 = '{lin, ang, crash_scan, flags.quad, unrec, !crash_scan};
		res1 = '{8'sd0, 8'sd0, 1'b1, flags.quad, unrec, 1'b1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lsar_pkg::NUM_SLOTS; i++) cnt_q[i] <= '0;
		end else if (fire_last) begin
			for (int i = 0; i < lsar_pkg::NUM_SLOTS; i++) begin
				if (!crash_scan) begin
					cnt_q[i] <= '0;
				end else if (cnt_we && e.slot == 3'(i)) begin
					cnt_q[i] <= cnt_next;
				end
			end
		end
	end

endmodule

// File: design/lsar_outq.sv
// Small result queue that takes up to two items per cycle and hands out one while out_stall is low.
module lsar_outq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         push_n,
	input  lsar_pkg::result_t  res0,
	input  lsar_pkg::result_t  res1,
	input  logic               out_stall,
	output logic               out_valid,
	output lsar_pkg::result_t  out_res,
	output logic               room
);

	localparam int PtrW = lsar_pkg::OQ_PTR_W;
	localparam int CntW = lsar_pkg::OQ_CNT_W;

	lsar_pkg::result_t ent_q [lsar_pkg::OQ_DEPTH];
	logic [PtrW-1:0] wr_q;
	logic [PtrW-1:0] rd_q;
	logic [CntW-1:0] count_q;
	logic pop;

	assign out_valid = (count_q != '0);
	assign out_res = ent_q[rd_q];
	assign pop = out_valid && !out_stall;
	assign room = (count_q <= CntW'(lsar_pkg::OQ_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) ent_q[wr_q] <= res0;
		if (push_n == 2'd2) ent_q[wr_q + PtrW'(1)] <= res1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			wr_q <= wr_q + PtrW'(push_n);
			if (pop) rd_q <= rd_q + PtrW'(1);
			count_q <= count_q + CntW'(push_n) - CntW'(pop);
		end
	end

endmodule

// File: design/lidar_sector_avoidance_reflex_unit.sv
// Top level of the lidar sector avoidance reflex unit with its register port.
//
// Range samples enter on the sample channel (sample_valid, sample_stall) with their
// angular index and a mark on the last sample of a scan. Samples that are not last give
// no item. On the last sample the unit gives one wall-following command, or, when a crash
// was seen during the scan, a recovery command followed by a zero stop command; the final
// item of a scan carries last_result.
// A sample is taken into an input register; once the queue has room it is classified
// and, if it is the last, decided, and its items are written to a four-entry output
// queue, which offers them in order. A sample can be accepted in every cycle while the
// queue has room. Sample intake stalls only while the queue holds more than two items,
// which happens when the receiver stalls the result channel. Thresholds are for the user
// to write through the register port only while the unit is idle; the unit itself does
// not enforce this. Reset clears the scan flags, the retry counters, the queue and the
// input register, and loads the register defaults.
module lidar_sector_avoidance_reflex_unit #(
	parameter int INDEX_BITS = lsar_pkg::INDEX_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lsar_pkg::ADDR_W-1:0]       paddr,
	input  logic [lsar_pkg::DATA_W-1:0]       pwdata,
	output logic [lsar_pkg::DATA_W-1:0]       prdata,
	output logic                              pready,
	input  logic                              sample_valid,
	output logic                              sample_stall,
	input  logic [INDEX_BITS-1:0]             sample_index,
	input  logic [lsar_pkg::RANGE_W-1:0]      range_mm,
	input  logic                              last_sample,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic signed [7:0]                 linear_cmd,
	output logic signed [7:0]                 angular_cmd,
	output logic                              crash_mode,
	output logic [3:0]                        quadrant_code,
	output logic                              unrecoverable,
	output logic                              last_result
);

	lsar_pkg::cfg_t cfg_q;
	logic [2:0] reg_sel;
	logic cfg_wr;

	logic valid_s1;
	logic [INDEX_BITS-1:0] index_s1;
	logic [lsar_pkg::RANGE_W-1:0] range_s1;
	logic last_s1;
	logic accept;
	logic fire;
	logic fire_last;
	logic room;

	lsar_pkg::flags_t flags;
	lsar_pkg::result_t res0;
	lsar_pkg::result_t res1;
	lsar_pkg::result_t out_res;
	logic crash_scan;
	logic [1:0] push_n;

	assign pready = 1'b1;
	assign reg_sel = paddr[4:2];
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		unique case (reg_sel)
			lsar_pkg::REG_WALL_THRESHOLD: prdata = 32'(cfg_q.wall_threshold_mm);
			lsar_pkg::REG_NEAR_CONTACT: prdata = 32'(cfg_q.near_contact_mm);
			lsar_pkg::REG_CRASH_REAR_LEFT: prdata = 32'(cfg_q.crash_rear_left_mm);
			lsar_pkg::REG_CRASH_REAR: prdata = 32'(cfg_q.crash_rear_mm);
			lsar_pkg::REG_CRASH_RIGHT: prdata = 32'(cfg_q.crash_right_mm);
			lsar_pkg::REG_CRASH_FRONT: prdata = 32'(cfg_q.crash_front_mm);
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wall_threshold_mm <= lsar_pkg::WALL_THRESHOLD_RST;
			cfg_q.near_contact_mm <= lsar_pkg::NEAR_CONTACT_RST;
			cfg_q.crash_rear_left_mm <= lsar_pkg::CRASH_REAR_LEFT_RST;
			cfg_q.crash_rear_mm <= lsar_pkg::CRASH_REAR_RST;
			cfg_q.crash_right_mm <= lsar_pkg::CRASH_RIGHT_RST;
			cfg_q.crash_front_mm <= lsar_pkg::CRASH_FRONT_RST;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				lsar_pkg::REG_WALL_THRESHOLD: cfg_q.wall_threshold_mm <= pwdata[15:0];
				lsar_pkg::REG_NEAR_CONTACT: cfg_q.near_contact_mm <= pwdata[15:0];
				lsar_pkg::REG_CRASH_REAR_LEFT: cfg_q.crash_rear_left_mm <= pwdata[15:0];
				lsar_pkg::REG_CRASH_REAR: cfg_q.crash_rear_mm <= pwdata[15:0];
				lsar_pkg::REG_CRASH_RIGHT: cfg_q.crash_right_mm <= pwdata[15:0];
				lsar_pkg::REG_CRASH_FRONT: cfg_q.crash_front_mm <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	assign fire = valid_s1 && room;
	assign fire_last = fire && last_s1;
	assign sample_stall = valid_s1 && !room;
	assign accept = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			index_s1 <= sample_index;
			range_s1 <= range_mm;
			last_s1 <= last_sample;
		end
	end

	lsar_scan #(
		.INDEX_BITS(INDEX_BITS)
	) u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.sample_index(index_s1),
		.range_mm(range_s1),
		.last_sample(last_s1),
		.cfg(cfg_q),
		.flags(flags)
	);

	lsar_decide u_decide (
		.clk(clk),
		.arst_n(arst_n),
		.fire_last(fire_last),
		.flags(flags),
		.res0(res0),
		.res1(res1),
		.crash_scan(crash_scan)
	);

	assign push_n = !fire_last ? 2'd0 : (crash_scan ? 2'd2 : 2'd1);

	lsar_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push_n(push_n),
		.res0(res0),
		.res1(res1),
		.out_stall(result_stall),
		.out_valid(result_valid),
		.out_res(out_res),
		.room(room)
	);

	assign linear_cmd = out_res.linear_cmd;
	assign angular_cmd = out_res.angular_cmd;
	assign crash_mode = out_res.crash_mode;
	assign quadrant_code = out_res.quadrant_code;
	assign unrecoverable = out_res.unrecoverable;
	assign last_result = out_res.last_result;

	a_last_gives_item: assert property (@(posedge clk) disable iff (!arst_n)
		fire_last |=> result_valid)
		else $error("No item offered after the last sample of a scan.");

	a_crash_has_quadrant: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && crash_mode |-> quadrant_code != 4'd0)
		else $error("Crash recovery item without a crash quadrant.");

	a_wall_item_form: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !crash_mode |-> last_result && quadrant_code == 4'd0 && !unrecoverable)
		else $error("Wall-following item with crash fields set.");

	a_stall_needs_sample: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> $past(fire) == 1'b0 || $past(fire_last) || !room)
		else $error("Sample intake stalled while the queue has room.");

endmodule
